### hdl/txs_pkg.sv
// Shared widths, codes and defaults of the tiled texel store.
package txs_pkg;

  localparam int unsigned STORE_BYTES_DEFAULT = 65536;

  localparam int unsigned COORD_W    = 10;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned WIDTH_W    = 11;
  localparam int unsigned CFG_DATA_W = 11;
  // Byte offsets reach (1023/4 + 255 * 511) * 64 + 63, which needs 23 bits plus headroom.
  localparam int unsigned ADDR_W     = 25;
  localparam int unsigned FIFO_DEPTH = 8;

  typedef enum logic [1:0] {
    FMT_RGBA8  = 2'd0,
    FMT_I8     = 2'd1,
    FMT_IA8    = 2'd2,
    FMT_UNUSED = 2'd3
  } fmt_t;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  localparam logic CFG_FORMAT = 1'b0;
  localparam logic CFG_WIDTH  = 1'b1;

  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 11'd128;

endpackage

### hdl/txs_if.sv
// Channel interfaces of the tiled texel store: requests, read results, configuration.
interface txs_req_if;
  import txs_pkg::*;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [COORD_W-1:0] x_coord;
  logic [COORD_W-1:0] y_coord;
  logic [BYTE_W-1:0]  in_red;
  logic [BYTE_W-1:0]  in_green;
  logic [BYTE_W-1:0]  in_blue;
  logic [BYTE_W-1:0]  in_alpha;
  modport source (output valid, cmd, x_coord, y_coord, in_red, in_green, in_blue, in_alpha,
                  input ready);
  modport sink (input valid, cmd, x_coord, y_coord, in_red, in_green, in_blue, in_alpha,
                output ready);
endinterface

interface txs_rsp_if;
  import txs_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_red;
  logic [BYTE_W-1:0] out_green;
  logic [BYTE_W-1:0] out_blue;
  logic [BYTE_W-1:0] out_alpha;
  logic              out_of_range;
  modport source (output valid, out_red, out_green, out_blue, out_alpha, out_of_range,
                  input ready);
  modport sink (input valid, out_red, out_green, out_blue, out_alpha, out_of_range,
                output ready);
endinterface

interface txs_cfg_if;
  import txs_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hdl/tiled_texel_store_unit.sv
// Tiled texel store: address pipeline, two byte-lane memory banks and a result queue.
//
// Usage: requests arrive on req (cmd, texel coordinates, colour bytes). A write
// transaction stores the texel in the tiled layout chosen by texel_format and
// gives no result; a read gives exactly one transaction on rsp, in request order.
// Registers are set on cfg (index 0 texel_format, index 1 image_width); the user
// must do so only with no request in flight (not enforced); cfg is always ready.
// Pipeline: a request passes an address stage (tile multiply), a placement stage
// (offset add and range compare) and a memory stage; a read result is then
// written into the queue, from which it can complete on rsp.
// One request per cycle is sustained while req.ready holds; the two 16-bit banks
// (split on byte address bit 5) let the four bytes of a colour texel move in one access.
// Up to eight reads may be outstanding; with eight unclaimed, req.ready drops
// until rsp takes a result, so a stalled receiver only stops new requests.
// Reset clears the pipeline, the queue and the registers (format 0, width 128);
// the store contents are undefined until written.
module tiled_texel_store_unit #(
  parameter int unsigned STORE_BYTES = txs_pkg::STORE_BYTES_DEFAULT
) (
  input logic       clk,
  input logic       rst,
  txs_req_if.sink   req,
  txs_rsp_if.source rsp,
  txs_cfg_if.sink   cfg
);
  import txs_pkg::*;

  localparam int unsigned BANK_DEPTH = ((STORE_BYTES + 63) / 64) * 16;
  localparam int unsigned IDX_W      = $clog2(BANK_DEPTH);
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

  // Highest base offset whose last touched byte still lies in the store.
  localparam logic [ADDR_W-1:0] LIM_RGBA8 = ADDR_W'(STORE_BYTES - 34);
  localparam logic [ADDR_W-1:0] LIM_I8    = ADDR_W'(STORE_BYTES - 1);
  localparam logic [ADDR_W-1:0] LIM_IA8   = ADDR_W'(STORE_BYTES - 2);

  typedef struct packed {
    logic              cmd;
    fmt_t              fmt;
    logic [7:0]        xt;
    logic [16:0]       prod;
    logic [1:0]        yr;
    logic [2:0]        xl;
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
    logic [BYTE_W-1:0] alpha;
  } addr_stage_t;

  typedef struct packed {
    logic             cmd;
    fmt_t             fmt;
    logic             oob;
    logic             sel;
    logic             lane;
    logic [IDX_W-1:0] idx;
    logic [1:0]       be0;
    logic [1:0]       be1;
    logic [15:0]      wd0;
    logic [15:0]      wd1;
  } place_stage_t;

  typedef struct packed {
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
    logic [BYTE_W-1:0] alpha;
    logic              oor;
  } result_t;

  fmt_t               texel_format;
  logic [WIDTH_W-1:0] image_width;

  logic         p1_valid, p2_valid, m_valid;
  addr_stage_t  p1, p1_next;
  place_stage_t p2, p2_next;
  fmt_t         m_fmt;
  logic         m_oob, m_sel, m_lane;
  logic [15:0]  rd0, rd1;

  logic [15:0] bank0 [BANK_DEPTH];
  logic [15:0] bank1 [BANK_DEPTH];

  result_t          fifo_mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] fifo_count, outstanding;

  logic        req_fire, read_fire, rsp_fire, push;
  logic [8:0]  tpr;
  logic [17:0] tile;
  logic [ADDR_W-1:0] base;
  logic [ADDR_W-3:0] idx_full;
  logic [1:0]  lane_mask;
  result_t     res;
  logic [15:0] word;
  logic [BYTE_W-1:0] byte_v;

  assign req.ready = (outstanding < CNT_W'(FIFO_DEPTH));
  assign cfg.ready = 1'b1;
  assign req_fire  = req.valid && req.ready;
  assign read_fire = req_fire && (req.cmd == CMD_READ);
  assign rsp_fire  = rsp.valid && rsp.ready;
  assign push      = m_valid;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      texel_format <= FMT_RGBA8;
      image_width  <= WIDTH_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_FORMAT: texel_format <= fmt_t'(cfg.data[1:0]);
        CFG_WIDTH:  image_width  <= cfg.data[WIDTH_W-1:0];
        default:    image_width  <= image_width;
      endcase
    end
  end

  // Address stage: tile column and the row product.
  always_comb begin
    tpr = (texel_format == FMT_I8) ? {1'b0, image_width[10:3]} : image_width[10:2];
    p1_next.cmd   = req.cmd;
    p1_next.fmt   = texel_format;
    p1_next.xt    = (texel_format == FMT_I8) ? {1'b0, req.x_coord[9:3]} : req.x_coord[9:2];
    p1_next.prod  = {9'b0, req.y_coord[9:2]} * {8'b0, tpr};
    p1_next.yr    = req.y_coord[1:0];
    p1_next.xl    = req.x_coord[2:0];
    p1_next.red   = req.in_red;
    p1_next.green = req.in_green;
    p1_next.blue  = req.in_blue;
    p1_next.alpha = req.in_alpha;
  end

  // Placement stage: byte offset, range check, bank lanes and write data.
  always_comb begin
    tile = {1'b0, p1.prod} + {10'b0, p1.xt};
    base = '0;
    p2_next.oob = 1'b1;
    case (p1.fmt)
      FMT_RGBA8: begin
        base = {1'b0, tile, 1'b0, p1.yr, p1.xl[1:0], 1'b0};
        p2_next.oob = (base > LIM_RGBA8);
      end
      FMT_I8: begin
        base = {2'b0, tile, p1.yr, p1.xl};
        p2_next.oob = (base > LIM_I8);
      end
      FMT_IA8: begin
        base = {2'b0, tile, p1.yr, p1.xl[1:0], 1'b0};
        p2_next.oob = (base > LIM_IA8);
      end
      default: begin
        base = '0;
        p2_next.oob = 1'b1;
      end
    endcase
    idx_full     = {base[ADDR_W-1:6], base[4:1]};
    p2_next.idx  = idx_full[IDX_W-1:0];
    p2_next.cmd  = p1.cmd;
    p2_next.fmt  = p1.fmt;
    p2_next.sel  = base[5];
    p2_next.lane = base[0];
    lane_mask    = base[0] ? 2'b10 : 2'b01;
    p2_next.wd0  = (p1.fmt == FMT_I8) ? {p1.red, p1.red} : {p1.red, p1.alpha};
    p2_next.wd1  = (p1.fmt == FMT_RGBA8) ? {p1.blue, p1.green} : p2_next.wd0;
    p2_next.be0  = 2'b00;
    p2_next.be1  = 2'b00;
    if (p1.cmd == CMD_WRITE && !p2_next.oob) begin
      case (p1.fmt)
        FMT_RGBA8: begin
          p2_next.be0 = 2'b11;
          p2_next.be1 = 2'b11;
        end
        FMT_I8: begin
          p2_next.be0 = base[5] ? 2'b00 : lane_mask;
          p2_next.be1 = base[5] ? lane_mask : 2'b00;
        end
        FMT_IA8: begin
          p2_next.be0 = base[5] ? 2'b00 : 2'b11;
          p2_next.be1 = base[5] ? 2'b11 : 2'b00;
        end
        default: begin
          p2_next.be0 = 2'b00;
          p2_next.be1 = 2'b00;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      m_valid  <= 1'b0;
    end else begin
      p1_valid <= req_fire;
      p2_valid <= p1_valid;
      m_valid  <= p2_valid && (p2.cmd == CMD_READ);
    end
  end

  always_ff @(posedge clk) begin
    p1     <= p1_next;
    p2     <= p2_next;
    m_fmt  <= p2.fmt;
    m_oob  <= p2.oob;
    m_sel  <= p2.sel;
    m_lane <= p2.lane;
  end

  // Bank 0 holds byte offsets with bit 5 clear, bank 1 those with bit 5 set.
  always_ff @(posedge clk) begin
    if (p2_valid && p2.be0[0]) begin
      bank0[p2.idx][7:0] <= p2.wd0[7:0];
    end
    if (p2_valid && p2.be0[1]) begin
      bank0[p2.idx][15:8] <= p2.wd0[15:8];
    end
    rd0 <= bank0[p2.idx];
  end

  always_ff @(posedge clk) begin
    if (p2_valid && p2.be1[0]) begin
      bank1[p2.idx][7:0] <= p2.wd1[7:0];
    end
    if (p2_valid && p2.be1[1]) begin
      bank1[p2.idx][15:8] <= p2.wd1[15:8];
    end
    rd1 <= bank1[p2.idx];
  end

  // Channel steering of the read data.
  always_comb begin
    word   = m_sel ? rd1 : rd0;
    byte_v = m_lane ? word[15:8] : word[7:0];
    res    = '0;
    if (m_oob) begin
      res.oor = 1'b1;
    end else begin
      case (m_fmt)
        FMT_RGBA8: begin
          res.red   = rd0[15:8];
          res.alpha = rd0[7:0];
          res.green = rd1[7:0];
          res.blue  = rd1[15:8];
        end
        FMT_I8: begin
          res.red   = byte_v;
          res.green = byte_v;
          res.blue  = byte_v;
          res.alpha = byte_v;
        end
        FMT_IA8: begin
          res.red   = word[15:8];
          res.green = word[15:8];
          res.blue  = word[15:8];
          res.alpha = word[7:0];
        end
        default: res.oor = 1'b1;
      endcase
    end
  end

  // Result queue; outstanding counts reads accepted but not yet delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr      <= '0;
      rd_ptr      <= '0;
      fifo_count  <= '0;
      outstanding <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rsp_fire) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fifo_count  <= fifo_count + CNT_W'(push) - CNT_W'(rsp_fire);
      outstanding <= outstanding + CNT_W'(read_fire) - CNT_W'(rsp_fire);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= res;
    end
  end

  assign rsp.valid        = (fifo_count != '0);
  assign rsp.out_red      = fifo_mem[rd_ptr].red;
  assign rsp.out_green    = fifo_mem[rd_ptr].green;
  assign rsp.out_blue     = fifo_mem[rd_ptr].blue;
  assign rsp.out_alpha    = fifo_mem[rd_ptr].alpha;
  assign rsp.out_of_range = fifo_mem[rd_ptr].oor;

  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    outstanding <= CNT_W'(FIFO_DEPTH))
    else $error("more reads outstanding than queue entries");

  a_queue_within_credit: assert property (@(posedge clk) disable iff (rst)
    fifo_count <= outstanding)
    else $error("queued results exceed outstanding reads");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (fifo_count < CNT_W'(FIFO_DEPTH)) || rsp_fire)
    else $error("result pushed into a full queue");

  a_read_no_write: assert property (@(posedge clk) disable iff (rst)
    (p2_valid && p2.cmd == CMD_READ) |-> (p2.be0 == 2'b00 && p2.be1 == 2'b00))
    else $error("read transaction carries byte enables");

  a_read_reaches_queue: assert property (@(posedge clk) disable iff (rst)
    (p2_valid && p2.cmd == CMD_READ) |=> push)
    else $error("read did not produce a queued result");

endmodule
